/* src/tpq_pkg.sv */
// Shared constants and types for the thick polyline quad generator.
package tpq_pkg;

   localparam int COORD_BITS  = 16;
   localparam int FRAC_BITS   = 4;
   localparam int WIDTH_BITS  = 12;
   localparam int WIDTH_FRAC  = 4;
   localparam int COUNT_BITS  = 16;
   localparam int OUT_BITS    = COORD_BITS + FRAC_BITS + 1;
   localparam int Q_BITS      = 17;
   localparam int BIT_BITS    = $clog2(Q_BITS);
   localparam int SQ_BITS     = 2 * COORD_BITS;
   localparam int S_BITS      = SQ_BITS + 1;
   localparam int SS_BITS     = S_BITS + 2 * WIDTH_FRAC;
   localparam int M_BITS      = WIDTH_BITS + FRAC_BITS;
   localparam int R_BITS      = COORD_BITS + M_BITS;
   localparam int T_BITS      = 2 * R_BITS;
   localparam int ACC_BITS    = T_BITS + 2 * Q_BITS;
   localparam int SHIFT_BITS  = $clog2(2 * Q_BITS + 2);
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
   localparam int FILL_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [WIDTH_BITS-1:0] LINE_WIDTH_RESET = WIDTH_BITS'(48);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX        = {COUNT_BITS{1'b1}};

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic signed [COORD_BITS-1:0] x2;
      logic signed [COORD_BITS-1:0] y2;
      logic [COUNT_BITS-1:0]        count;
   } seg_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

endpackage

/* src/thick_polyline_quad_generator.sv */
// Thick polyline quad generator: polyline points in, stroke quad corners out.
// Points are taken whenever the two-entry segment queue has room; first points
// and zero-length segments update state and produce no transfer. In the back end
// each real segment is loaded and its squared length is formed; then, per normal
// axis, the r and t products are formed and a bit-serial rounded root/divide
// search runs; then the output register is loaded. That search unit,
// shared by both axes, sets the throughput. line_width is written through
// csr_write_enable/csr_write_data, Q8.4, reset 48.
module thick_polyline_quad_generator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tpq_pkg::WIDTH_BITS-1:0]       csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tpq_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [tpq_pkg::COORD_BITS-1:0] req_point_y,
   input  logic                                 req_starts_line,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner0_x,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner0_y,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner1_x,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner1_y,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner2_x,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner2_y,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner3_x,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner3_y,
   output logic [tpq_pkg::COUNT_BITS-1:0]       rsp_segments_drawn
);
   import tpq_pkg::*;

   queue_status_type queue_status;
   logic             push;
   logic             pop;
   seg_type          push_data;
   seg_type          pop_data;

   tpq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_starts_line (req_starts_line),
      .queue_status    (queue_status),
      .push            (push),
      .push_data       (push_data)
   );

   tpq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   tpq_back u_back (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .queue_status       (queue_status),
      .pop_data           (pop_data),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_corner0_x      (rsp_corner0_x),
      .rsp_corner0_y      (rsp_corner0_y),
      .rsp_corner1_x      (rsp_corner1_x),
      .rsp_corner1_y      (rsp_corner1_y),
      .rsp_corner2_x      (rsp_corner2_x),
      .rsp_corner2_y      (rsp_corner2_y),
      .rsp_corner3_x      (rsp_corner3_x),
      .rsp_corner3_y      (rsp_corner3_y),
      .rsp_segments_drawn (rsp_segments_drawn)
   );

endmodule

/* src/tpq_front.sv */
// Front end: tracks the previous point, classifies points, queues real segments.
module tpq_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [tpq_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [tpq_pkg::COORD_BITS-1:0] req_point_y,
   input  logic                                 req_starts_line,
   input  tpq_pkg::queue_status_type            queue_status,
   output logic                                 push,
   output tpq_pkg::seg_type                     push_data
);
   import tpq_pkg::*;

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic signed [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic                         have_prev_ff, have_prev_in;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic                         accept;
   logic [COUNT_BITS-1:0]        count_next;

   assign req_ready  = !queue_status.full;
   assign accept     = req_valid && req_ready;
   assign count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + COUNT_BITS'(1);

   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      count_in     = count_ff;
      push         = 1'b0;
      push_data.x1    = prev_x_ff;
      push_data.y1    = prev_y_ff;
      push_data.x2    = req_point_x;
      push_data.y2    = req_point_y;
      push_data.count = count_next;
      if (accept) begin
         prev_x_in = req_point_x;
         prev_y_in = req_point_y;
         if (req_starts_line || !have_prev_ff) begin
            have_prev_in = 1'b1;
            count_in     = '0;
         end else if (req_point_x != prev_x_ff || req_point_y != prev_y_ff) begin
            count_in = count_next;
            push     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         count_ff     <= count_in;
      end
   end

endmodule

/* src/tpq_queue.sv */
// Short segment queue between front and back ends.
module tpq_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tpq_pkg::seg_type          push_data,
   input  logic                      pop,
   output tpq_pkg::seg_type          pop_data,
   output tpq_pkg::queue_status_type status
);
   import tpq_pkg::*;

   seg_type               mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_BITS-1:0]  fill_ff, fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = (fill_ff == FILL_BITS'(QUEUE_DEPTH));
   assign status.valid = (fill_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign pop_data     = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_BITS'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* src/tpq_back.sv */
// Back end: normal offset by bit-serial rounded root search, corner assembly.
module tpq_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tpq_pkg::WIDTH_BITS-1:0]       csr_write_data,
   input  tpq_pkg::queue_status_type            queue_status,
   input  tpq_pkg::seg_type                     pop_data,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner0_x,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner0_y,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner1_x,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner1_y,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner2_x,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner2_y,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner3_x,
   output logic signed [tpq_pkg::OUT_BITS-1:0]  rsp_corner3_y,
   output logic [tpq_pkg::COUNT_BITS-1:0]       rsp_segments_drawn
);
   import tpq_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SQUARE = 6'b000010,
      S_MUL_R  = 6'b000100,
      S_MUL_T  = 6'b001000,
      S_ITER   = 6'b010000,
      S_EMIT   = 6'b100000
   } state_type;

   state_type                    state_ff, state_in;
   logic [WIDTH_BITS-1:0]        width_ff, width_in;
   seg_type                      seg_ff, seg_in;
   logic [COORD_BITS-1:0]        adx_ff, adx_in, ady_ff, ady_in;
   logic                         dx_neg_ff, dx_neg_in, dy_pos_ff, dy_pos_in;
   logic [S_BITS-1:0]            s_ff, s_in;
   logic [R_BITS-1:0]            r_ff, r_in;
   logic [T_BITS-1:0]            t_ff, t_in;
   logic signed [ACC_BITS-1:0]   acc_a_ff, acc_a_in, acc_b_ff, acc_b_in;
   logic [Q_BITS-1:0]            q_ff, q_in, nx_mag_ff, nx_mag_in;
   logic [BIT_BITS-1:0]          bit_ff, bit_in;
   logic                         axis_ff, axis_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_BITS-1:0]   c0x_ff, c0x_in, c0y_ff, c0y_in, c1x_ff, c1x_in;
   logic signed [OUT_BITS-1:0]   c1y_ff, c1y_in, c2x_ff, c2x_in, c2y_ff, c2y_in;
   logic signed [OUT_BITS-1:0]   c3x_ff, c3x_in, c3y_ff, c3y_in;
   logic [COUNT_BITS-1:0]        cnt_ff, cnt_in;

   logic signed [COORD_BITS:0]   dx, dy;
   logic [SQ_BITS-1:0]           sq_x, sq_y;
   logic [M_BITS-1:0]            m_val;
   logic [COORD_BITS-1:0]        mag;
   logic [R_BITS-1:0]            r_prod;
   logic [T_BITS-1:0]            t_prod;
   logic signed [ACC_BITS-1:0]   ss, sh_b, sh_s, cand, t_ext;
   logic [SHIFT_BITS-1:0]        sh1, sh2;
   logic                         take;
   logic [Q_BITS-1:0]            q_next;
   logic signed [OUT_BITS-1:0]   bx1, by1, bx2, by2, nx, ny;

   assign dx     = {pop_data.x2[COORD_BITS-1], pop_data.x2}
                 - {pop_data.x1[COORD_BITS-1], pop_data.x1};
   assign dy     = {pop_data.y2[COORD_BITS-1], pop_data.y2}
                 - {pop_data.y1[COORD_BITS-1], pop_data.y1};
   assign sq_x   = adx_ff * adx_ff;
   assign sq_y   = ady_ff * ady_ff;
   assign m_val  = {width_ff, {FRAC_BITS{1'b0}}};
   assign mag    = axis_ff ? adx_ff : ady_ff;
   assign r_prod = mag * m_val;
   assign t_prod = r_ff * r_ff;
   assign ss     = ACC_BITS'({s_ff, {(2 * WIDTH_FRAC){1'b0}}});
   assign sh1    = SHIFT_BITS'(bit_ff) + SHIFT_BITS'(2);
   assign sh2    = SHIFT_BITS'({bit_ff, 1'b0}) + SHIFT_BITS'(2);
   assign sh_b   = acc_b_ff <<< sh1;
   assign sh_s   = ss <<< sh2;
   assign cand   = acc_a_ff + sh_b + sh_s;
   assign t_ext  = ACC_BITS'(t_ff);
   assign take   = (cand <= t_ext);
   assign q_next = take ? (q_ff | (Q_BITS'(1) << bit_ff)) : q_ff;

   assign bx1 = OUT_BITS'(seg_ff.x1) <<< FRAC_BITS;
   assign by1 = OUT_BITS'(seg_ff.y1) <<< FRAC_BITS;
   assign bx2 = OUT_BITS'(seg_ff.x2) <<< FRAC_BITS;
   assign by2 = OUT_BITS'(seg_ff.y2) <<< FRAC_BITS;
   assign nx  = dy_pos_ff ? -$signed(OUT_BITS'(nx_mag_ff)) : $signed(OUT_BITS'(nx_mag_ff));
   assign ny  = dx_neg_ff ? -$signed(OUT_BITS'(q_ff)) : $signed(OUT_BITS'(q_ff));

   always_comb begin
      state_in     = state_ff;
      width_in     = csr_write_enable ? csr_write_data : width_ff;
      seg_in       = seg_ff;
      adx_in       = adx_ff;
      ady_in       = ady_ff;
      dx_neg_in    = dx_neg_ff;
      dy_pos_in    = dy_pos_ff;
      s_in         = s_ff;
      r_in         = r_ff;
      t_in         = t_ff;
      acc_a_in     = acc_a_ff;
      acc_b_in     = acc_b_ff;
      q_in         = q_ff;
      nx_mag_in    = nx_mag_ff;
      bit_in       = bit_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      c0x_in = c0x_ff; c0y_in = c0y_ff; c1x_in = c1x_ff; c1y_in = c1y_ff;
      c2x_in = c2x_ff; c2y_in = c2y_ff; c3x_in = c3x_ff; c3y_in = c3y_ff;
      cnt_in       = cnt_ff;
      pop          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (queue_status.valid) begin
               pop       = 1'b1;
               seg_in    = pop_data;
               adx_in    = COORD_BITS'(dx[COORD_BITS] ? -dx : dx);
               ady_in    = COORD_BITS'(dy[COORD_BITS] ? -dy : dy);
               dx_neg_in = dx[COORD_BITS];
               dy_pos_in = !dy[COORD_BITS] && (dy != '0);
               state_in  = S_SQUARE;
            end
         end
         S_SQUARE: begin
            s_in     = S_BITS'(sq_x) + S_BITS'(sq_y);
            axis_in  = 1'b0;
            state_in = S_MUL_R;
         end
         S_MUL_R: begin
            r_in     = r_prod;
            state_in = S_MUL_T;
         end
         S_MUL_T: begin
            t_in     = t_prod;
            acc_a_in = ss;
            acc_b_in = -ss;
            q_in     = '0;
            bit_in   = BIT_BITS'(Q_BITS - 1);
            state_in = S_ITER;
         end
         S_ITER: begin
            q_in = q_next;
            if (take) begin
               acc_a_in = cand;
               acc_b_in = acc_b_ff + (ss <<< (sh1 - SHIFT_BITS'(1)));
            end
            if (bit_ff == '0) begin
               if (!axis_ff) begin
                  nx_mag_in = q_next;
                  axis_in   = 1'b1;
                  state_in  = S_MUL_R;
               end else begin
                  state_in = S_EMIT;
               end
            end else begin
               bit_in = bit_ff - BIT_BITS'(1);
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               c0x_in = bx1 + nx; c0y_in = by1 + ny;
               c1x_in = bx1 - nx; c1y_in = by1 - ny;
               c2x_in = bx2 - nx; c2y_in = by2 - ny;
               c3x_in = bx2 + nx; c3y_in = by2 + ny;
               cnt_in   = seg_ff.count;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= LINE_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff    <= seg_in;
      adx_ff    <= adx_in;
      ady_ff    <= ady_in;
      dx_neg_ff <= dx_neg_in;
      dy_pos_ff <= dy_pos_in;
      s_ff      <= s_in;
      r_ff      <= r_in;
      t_ff      <= t_in;
      acc_a_ff  <= acc_a_in;
      acc_b_ff  <= acc_b_in;
      q_ff      <= q_in;
      nx_mag_ff <= nx_mag_in;
      bit_ff    <= bit_in;
      axis_ff   <= axis_in;
      c0x_ff <= c0x_in; c0y_ff <= c0y_in; c1x_ff <= c1x_in; c1y_ff <= c1y_in;
      c2x_ff <= c2x_in; c2y_ff <= c2y_in; c3x_ff <= c3x_in; c3y_ff <= c3y_in;
      cnt_ff    <= cnt_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_corner0_x      = c0x_ff;
   assign rsp_corner0_y      = c0y_ff;
   assign rsp_corner1_x      = c1x_ff;
   assign rsp_corner1_y      = c1y_ff;
   assign rsp_corner2_x      = c2x_ff;
   assign rsp_corner2_y      = c2y_ff;
   assign rsp_corner3_x      = c3x_ff;
   assign rsp_corner3_y      = c3y_ff;
   assign rsp_segments_drawn = cnt_ff;

endmodule

/* tb/tpq_checker.sv */
// Checker for the quad generator: predicts stroke quads and compares each rsp transfer.
`timescale 1ns / 1ps
module tpq_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [tpq_pkg::WIDTH_BITS-1:0]        csr_write_data,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic signed [tpq_pkg::COORD_BITS-1:0] req_point_x,
   input  logic signed [tpq_pkg::COORD_BITS-1:0] req_point_y,
   input  logic                                  req_starts_line,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic signed [tpq_pkg::OUT_BITS-1:0]   rsp_corner0_x,
   input  logic signed [tpq_pkg::OUT_BITS-1:0]   rsp_corner0_y,
   input  logic signed [tpq_pkg::OUT_BITS-1:0]   rsp_corner1_x,
   input  logic signed [tpq_pkg::OUT_BITS-1:0]   rsp_corner1_y,
   input  logic signed [tpq_pkg::OUT_BITS-1:0]   rsp_corner2_x,
   input  logic signed [tpq_pkg::OUT_BITS-1:0]   rsp_corner2_y,
   input  logic signed [tpq_pkg::OUT_BITS-1:0]   rsp_corner3_x,
   input  logic signed [tpq_pkg::OUT_BITS-1:0]   rsp_corner3_y,
   input  logic [tpq_pkg::COUNT_BITS-1:0]        rsp_segments_drawn,
   output int                                    failures,
   output int                                    pending
);
   import tpq_pkg::*;

   typedef struct {
      logic [OUT_BITS-1:0]   cx[4];
      logic [OUT_BITS-1:0]   cy[4];
      logic [COUNT_BITS-1:0] count;
   } quad_type;

   quad_type quads_due[$];
   logic [WIDTH_BITS-1:0] stroke_width;
   int   last_x, last_y;
   bit   have_last;
   int   drawn;

   // largest q with (2q-1)^2 * 4^WIDTH_FRAC * s <= mag^2 * M^2, M = width << FRAC_BITS
   function automatic logic [Q_BITS-1:0] offset_mag(longint mag, longint s,
                                                     logic [WIDTH_BITS-1:0] w);
      logic [127:0] lhs, rhs, m;
      logic [Q_BITS-1:0] q, t;
      logic [127:0] odd;
      m = 128'(w) << FRAC_BITS;
      rhs = 128'(mag) * 128'(mag) * m * m;
      q = '0;
      for (int b = Q_BITS - 1; b >= 0; b--) begin
         t = q | (Q_BITS'(1) << b);
         odd = 2 * 128'(t) - 1;
         lhs = ((odd * odd) << (2 * WIDTH_FRAC)) * 128'(s);
         if (lhs <= rhs) q = t;
      end
      return q;
   endfunction

   function automatic void check_field(string name, logic [OUT_BITS-1:0] want,
                                       logic [OUT_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h got %0h", $time, name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      int dx, dy, nx, ny;
      longint adx, ady, s;
      quad_type q, want;
      if (reset) begin
         quads_due.delete();
         stroke_width = LINE_WIDTH_RESET;
         last_x = 0;
         last_y = 0;
         have_last = 0;
         drawn = 0;
      end else begin
         if (csr_write_enable) stroke_width = csr_write_data;
         if (rsp_valid && rsp_ready) begin
            if (quads_due.size() == 0) begin
               $display("%0t: unexpected transfer, expected none got %0h %0h", $time,
                        rsp_corner0_x, rsp_segments_drawn);
               failures++;
            end else begin
               want = quads_due.pop_front();
               check_field("corner0_x", want.cx[0], rsp_corner0_x);
               check_field("corner0_y", want.cy[0], rsp_corner0_y);
               check_field("corner1_x", want.cx[1], rsp_corner1_x);
               check_field("corner1_y", want.cy[1], rsp_corner1_y);
               check_field("corner2_x", want.cx[2], rsp_corner2_x);
               check_field("corner2_y", want.cy[2], rsp_corner2_y);
               check_field("corner3_x", want.cx[3], rsp_corner3_x);
               check_field("corner3_y", want.cy[3], rsp_corner3_y);
               check_field("segments_drawn", OUT_BITS'(want.count),
                           OUT_BITS'(rsp_segments_drawn));
            end
         end
         if (req_valid && req_ready) begin
            dx = int'(req_point_x) - last_x;
            dy = int'(req_point_y) - last_y;
            if (req_starts_line || !have_last) begin
               have_last = 1'b1;
               drawn = 0;
            end else if (dx != 0 || dy != 0) begin
               adx = longint'(dx < 0 ? -dx : dx);
               ady = longint'(dy < 0 ? -dy : dy);
               s = adx * adx + ady * ady;
               nx = int'(offset_mag(ady, s, stroke_width));
               ny = int'(offset_mag(adx, s, stroke_width));
               if (dy > 0) nx = -nx;
               if (dx < 0) ny = -ny;
               if (drawn < 65535) drawn++;
               q.cx[0] = OUT_BITS'(last_x * 16 + nx);
               q.cy[0] = OUT_BITS'(last_y * 16 + ny);
               q.cx[1] = OUT_BITS'(last_x * 16 - nx);
               q.cy[1] = OUT_BITS'(last_y * 16 - ny);
               q.cx[2] = OUT_BITS'(int'(req_point_x) * 16 - nx);
               q.cy[2] = OUT_BITS'(int'(req_point_y) * 16 - ny);
               q.cx[3] = OUT_BITS'(int'(req_point_x) * 16 + nx);
               q.cy[3] = OUT_BITS'(int'(req_point_y) * 16 + ny);
               q.count = COUNT_BITS'(drawn);
               quads_due.insert(quads_due.size(), q);
            end
            last_x = int'(req_point_x);
            last_y = int'(req_point_y);
         end
      end
      pending = quads_due.size();
   end

   initial begin
      failures = 0;
      pending = 0;
   end

endmodule

/* tb/tb.sv */
// Testbench top for the quad generator: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb;
   import tpq_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [WIDTH_BITS-1:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_ready;
   logic signed [COORD_BITS-1:0] req_point_x = '0;
   logic signed [COORD_BITS-1:0] req_point_y = '0;
   logic req_starts_line = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [OUT_BITS-1:0] rsp_corner0_x, rsp_corner0_y, rsp_corner1_x, rsp_corner1_y;
   logic signed [OUT_BITS-1:0] rsp_corner2_x, rsp_corner2_y, rsp_corner3_x, rsp_corner3_y;
   logic [COUNT_BITS-1:0] rsp_segments_drawn;
   int failures, pending;
   bit long_hold = 0;
   int points_sent = 0;
   int cur_x, cur_y;

   thick_polyline_quad_generator i_dut (.*);
   tpq_checker i_checker (.*);

   initial forever #4 clock = ~clock;

   // receiver
   initial forever begin
      @(posedge clock);
      if (long_hold) begin
         rsp_ready <= 0;
         repeat (600) @(posedge clock);
         long_hold = 0;
      end else if ($urandom_range(0, 99) < 3) begin
         rsp_ready <= 0;
         repeat ($urandom_range(10, 80)) @(posedge clock);
      end else if ($urandom_range(0, 1)) begin
         rsp_ready <= 1;
         repeat ($urandom_range(0, 40)) @(posedge clock);
      end else begin
         rsp_ready <= 1'($urandom_range(0, 1));
      end
   end

   // watchdog
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   task automatic send_point(int x, int y, bit first);
      int gap;
      case ($urandom_range(0, 9))
         0: gap = $urandom_range(10, 60);
         1, 2, 3, 4: gap = $urandom_range(1, 3);
         default: gap = 0;
      endcase
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_point_x <= COORD_BITS'(x);
      req_point_y <= COORD_BITS'(y);
      req_starts_line <= first;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      cur_x = x;
      cur_y = y;
      points_sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic set_width(logic [WIDTH_BITS-1:0] w);
      csr_write_enable <= 1;
      csr_write_data <= w;
      @(posedge clock);
      csr_write_enable <= 0;
   endtask

   function automatic int clamp_coord(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   task automatic random_polyline(int span);
      int n;
      n = $urandom_range(2, 12);
      send_point($signed(16'($urandom)), $signed(16'($urandom)), 1);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 19) == 0)
            send_point(cur_x, cur_y, 0);
         else if ($urandom_range(0, 9) == 0)
            send_point($signed(16'($urandom)), $signed(16'($urandom)), 0);
         else
            send_point(clamp_coord(cur_x + $signed($urandom_range(0, 2 * span)) - span),
                       clamp_coord(cur_y + $signed($urandom_range(0, 2 * span)) - span), 0);
      end
   endtask

   initial begin
      logic [WIDTH_BITS-1:0] widths[6];
      widths = '{12'd0, 12'd4095, 12'd1, 12'd48, 12'd0, 12'd0};
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset width
      send_point(5, 5, 0);
      send_point(5, 5, 0);
      send_point(9, 5, 0);
      send_point(9, 1, 0);
      send_point(-32768, -32768, 1);
      send_point(32767, 32767, 0);
      send_point(32767, -32768, 0);
      send_point(-32768, 32767, 0);
      send_point(-32768, 32767, 0);
      send_point(-32768, -32768, 0);
      send_point(32767, -32768, 0);
      send_point(0, 0, 1);
      send_point(3, 4, 0);
      send_point(-1, 1, 0);
      drain();

      // sender keeps offering while the receiver is held off
      long_hold = 1;
      for (int k = 0; k < 6; k++) random_polyline(300);
      drain();

      widths[4] = WIDTH_BITS'($urandom_range(2, 4094));
      widths[5] = WIDTH_BITS'($urandom_range(2, 4094));
      for (int p = 0; p < 6; p++) begin
         set_width(widths[p]);
         send_point(0, 0, 1);
         send_point(1, 1, 0);
         send_point(-2, 3, 0);
         send_point(-32768, 32767, 0);
         while (points_sent < 230 * (p + 1)) random_polyline(p[0] ? 40000 : 500);
         drain();
      end

      if (failures == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule
